// ----- rtl/priority_interrupt_controller_unit_defines.svh -----
// assertion helpers used by the controller top module
`ifndef PRIORITY_INTERRUPT_CONTROLLER_UNIT_DEFINES_SVH
`define PRIORITY_INTERRUPT_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is low
`define PIC_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is low
`define PIC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/pic_pkg.sv -----
package pic_pkg;

	localparam int unsigned PIC_NUM_SOURCES = 8;

	// request kinds
	localparam logic [2:0] REQ_DATA_WR = 3'd0;
	localparam logic [2:0] REQ_CMD_WR  = 3'd1;
	localparam logic [2:0] REQ_DATA_RD = 3'd2;
	localparam logic [2:0] REQ_RAISE   = 3'd3;
	localparam logic [2:0] REQ_CLEAR   = 3'd4;
	localparam logic [2:0] REQ_EVAL    = 3'd5;

	// command codes, high nibble of a command write
	localparam logic [3:0] CMD_RESET        = 4'd0;
	localparam logic [3:0] CMD_CLR_REQ_MASK = 4'd2;
	localparam logic [3:0] CMD_SET_MASK     = 4'd3;
	localparam logic [3:0] CMD_CLR_REQ      = 4'd4;
	localparam logic [3:0] CMD_CLR_LOW_ISR  = 4'd6;
	localparam logic [3:0] CMD_CLR_ISR      = 4'd7;
	localparam logic [3:0] CMD_MODE_A       = 4'd8;
	localparam logic [3:0] CMD_MODE_B       = 4'd9;
	localparam logic [3:0] CMD_PRESEL       = 4'd10;
	localparam logic [3:0] CMD_PTR_MASK     = 4'd11;
	localparam logic [3:0] CMD_PTR_ACR      = 4'd12;
	localparam logic [3:0] CMD_PTR_VEC      = 4'd14;

	// data port pointer targets other than the vectors
	localparam logic [3:0] PTR_MASK_REG = 4'd8;
	localparam logic [3:0] PTR_ACR_REG  = 4'd9;

	// read preselect
	localparam logic [1:0] PRESEL_ISR  = 2'd0;
	localparam logic [1:0] PRESEL_MASK = 2'd1;
	localparam logic [1:0] PRESEL_REQ  = 2'd2;
	localparam logic [1:0] PRESEL_ACR  = 2'd3;

	// master mask control in the preselect command
	localparam logic [1:0] MASTER_SET = 2'd1;
	localparam logic [1:0] MASTER_CLR = 2'd2;

	localparam logic [7:0] VECTOR_MASK = 8'hFC;

	typedef struct packed {
		logic       master;
		logic [1:0] presel;
		logic [4:0] load;
	} pic_mode_t;

	typedef struct packed {
		logic [7:0] req;
		logic [7:0] mask;
		logic [7:0] svc;
		logic [7:0] acr;
		pic_mode_t  mode;
		logic [3:0] ptr;
	} pic_state_t;

	localparam pic_state_t PIC_STATE_RESET = '{
		req: 8'h00, mask: 8'hFF, svc: 8'h00, acr: 8'h00, mode: '0, ptr: 4'h0
	};

	// vector table update from one request
	typedef struct packed {
		logic       we;
		logic [2:0] idx;
		logic [7:0] data;
		logic       clr;
	} pic_vec_wr_t;

	function automatic logic [7:0] lowest_one(input logic [7:0] x);
		return x & (~x + 8'd1);
	endfunction

	function automatic logic [7:0] src_mask(input int unsigned n);
		logic [7:0] m;
		for (int unsigned i = 0; i < 8; i++) begin
			m[i] = (i < n);
		end
		return m;
	endfunction

endpackage

// ----- rtl/priority_interrupt_controller_unit.sv -----
// eight-source vectored interrupt controller
// s_axis carries one request per transfer: a data-port write, a command-port
// write, a data-port read, a source raise or clear, or a plain re-evaluation.
// tuser holds the request kind, tdata the byte, source number and the two
// host levels (serial controller pending, interrupt enable).
// m_axis returns exactly one result per request: read byte (zero unless a
// read), request line, driven vector and the in-service register.
// a request is held in the input register; the controller state and the
// result register update together when it moves on, so each result is
// offered from the result register. one request per cycle is sustained while
// m_axis does not stall: the state update is a single combinational pass
// (command decode, priority pick over the sources) between those two
// registers.
// when m_axis stalls the result holds, the input register still takes one
// more request, then s_axis_tready drops until the result is taken.
// reset masks all sources, clears all other controller registers and vectors,
// drops the request line and empties both registers.
`include "priority_interrupt_controller_unit_defines.svh"

module priority_interrupt_controller_unit #(
	parameter int unsigned NUM_SOURCES = pic_pkg::PIC_NUM_SOURCES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// write_value[7:0], source_index[10:8], duart_pending[11],
	// interrupt_enable[12], zero[15:13]
	input  logic [15:0] s_axis_tdata,
	// req_type[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_data[7:0], irq_request[8], irq_vector[16:9], in_service[24:17],
	// zero[31:25]
	output logic [31:0] m_axis_tdata
);
	import pic_pkg::*;

	localparam logic [7:0] SRC_MASK = src_mask(NUM_SOURCES);

	// input register
	logic       valid_s1;
	logic [2:0] req_type_s1;
	logic [7:0] wval_s1;
	logic [2:0] src_s1;
	logic       duart_s1;
	logic       ien_s1;

	// result register
	logic       valid_s2;
	logic [7:0] rdata_s2;

	// controller state
	pic_state_t st_q;
	logic [7:0] vec_q [NUM_SOURCES];
	logic       line_q;
	logic [7:0] dvec_q;

	pic_state_t  st_act;
	pic_vec_wr_t vec_wr;
	logic [7:0]  rdata_nxt;
	logic [7:0]  vec_nxt [NUM_SOURCES];
	pic_state_t  st_nxt;
	logic        line_nxt;
	logic [7:0]  dvec_nxt;
	logic        do_eval;
	logic        adv;

	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign do_eval       = req_type_s1 != REQ_DATA_RD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_type_s1 <= s_axis_tuser;
			wval_s1     <= s_axis_tdata[7:0];
			src_s1      <= s_axis_tdata[10:8];
			duart_s1    <= s_axis_tdata[11];
			ien_s1      <= s_axis_tdata[12];
		end
	end

	pic_action #(
		.NUM_SOURCES(NUM_SOURCES)
	) u_action (
		.cur         (st_q),
		.req_type    (req_type_s1),
		.write_value (wval_s1),
		.source_index(src_s1),
		.nxt         (st_act),
		.vec_wr      (vec_wr),
		.read_data   (rdata_nxt)
	);

	for (genvar i = 0; i < NUM_SOURCES; i++) begin : g_vec
		always_comb begin
			if (vec_wr.clr) begin
				vec_nxt[i] = 8'h00;
			end else if (vec_wr.we && vec_wr.idx == 3'(i)) begin
				vec_nxt[i] = vec_wr.data;
			end else begin
				vec_nxt[i] = vec_q[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vec_q[i] <= 8'h00;
			end else if (adv) begin
				vec_q[i] <= vec_nxt[i];
			end
		end
	end

	pic_resolve #(
		.NUM_SOURCES(NUM_SOURCES)
	) u_resolve (
		.st_in           (st_act),
		.vec             (vec_nxt),
		.do_eval         (do_eval),
		.duart_pending   (duart_s1),
		.interrupt_enable(ien_s1),
		.line_in         (line_q),
		.dvec_in         (dvec_q),
		.st_out          (st_nxt),
		.line_out        (line_nxt),
		.dvec_out        (dvec_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= PIC_STATE_RESET;
			line_q   <= 1'b0;
			dvec_q   <= 8'h00;
			valid_s2 <= 1'b0;
		end else begin
			if (adv) begin
				st_q     <= st_nxt;
				line_q   <= line_nxt;
				dvec_q   <= dvec_nxt;
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rdata_s2 <= rdata_nxt;
		end
	end

	// line, vector and in-service only change together with the result register
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'b0, st_q.svc, dvec_q, line_q, rdata_s2};

	`PIC_ASSERT_NOW(a_line_has_service, clk, arst_n, line_q, st_q.svc != 8'h00,
		"request line up with empty in-service register")
	`PIC_ASSERT_NEXT(a_read_keeps_state, clk, arst_n, adv && !do_eval,
		$stable(st_q) && $stable(line_q) && $stable(dvec_q),
		"data read changed controller state")
	`PIC_ASSERT_NEXT(a_master_off_drops, clk, arst_n,
		adv && do_eval && !st_nxt.mode.master, !line_q,
		"request line up with master mask clear")
	`PIC_ASSERT_NOW(a_vector_aligned, clk, arst_n, 1'b1, dvec_q[1:0] == 2'b00,
		"driven vector not aligned")
	`PIC_ASSERT_NOW(a_no_foreign_req, clk, arst_n, 1'b1, (st_q.req & ~SRC_MASK) == 8'h00,
		"request bit set beyond the source count")

endmodule

// ----- rtl/pic_action.sv -----
module pic_action #(
	parameter int unsigned NUM_SOURCES = pic_pkg::PIC_NUM_SOURCES
) (
	input  pic_pkg::pic_state_t  cur,
	input  logic [2:0]           req_type,
	input  logic [7:0]           write_value,
	input  logic [2:0]           source_index,
	output pic_pkg::pic_state_t  nxt,
	output pic_pkg::pic_vec_wr_t vec_wr,
	output logic [7:0]           read_data
);
	import pic_pkg::*;

	localparam logic [7:0] SRC_MASK = src_mask(NUM_SOURCES);
	localparam logic [3:0] NUM_W    = 4'(NUM_SOURCES);

	logic [3:0] cmd;
	logic       one;
	logic [7:0] cmd_bit;
	logic [7:0] src_bit;
	logic       src_ok;

	assign cmd     = write_value[7:4];
	assign one     = write_value[3];
	assign cmd_bit = 8'd1 << write_value[2:0];
	assign src_bit = 8'd1 << source_index;
	assign src_ok  = {1'b0, source_index} < NUM_W;

	always_comb begin
		nxt       = cur;
		vec_wr    = '0;
		read_data = 8'h00;
		unique case (req_type)
			REQ_DATA_WR: begin
				if (cur.ptr == PTR_MASK_REG) begin
					nxt.mask = write_value;
				end else if (cur.ptr == PTR_ACR_REG) begin
					nxt.acr = write_value;
				end else begin
					vec_wr.we   = 1'b1;
					vec_wr.idx  = cur.ptr[2:0];
					vec_wr.data = write_value & VECTOR_MASK;
				end
			end
			REQ_CMD_WR: begin
				unique case (cmd)
					CMD_RESET: begin
						nxt        = PIC_STATE_RESET;
						vec_wr.clr = 1'b1;
					end
					CMD_CLR_REQ_MASK: begin
						if (one) begin
							nxt.req  = cur.req & ~cmd_bit;
							nxt.mask = cur.mask & ~cmd_bit;
						end else begin
							nxt.req  = 8'h00;
							nxt.mask = 8'h00;
						end
					end
					CMD_SET_MASK: nxt.mask = one ? (cur.mask | cmd_bit) : 8'hFF;
					CMD_CLR_REQ:  nxt.req = one ? (cur.req & ~cmd_bit) : 8'h00;
					CMD_CLR_LOW_ISR: nxt.svc = cur.svc & ~lowest_one(cur.svc & SRC_MASK);
					CMD_CLR_ISR:  nxt.svc = one ? (cur.svc & ~cmd_bit) : 8'h00;
					CMD_MODE_A, CMD_MODE_B: nxt.mode.load = write_value[4:0];
					CMD_PRESEL: begin
						nxt.mode.presel = write_value[3:2];
						if (write_value[1:0] == MASTER_SET) begin
							nxt.mode.master = 1'b1;
						end else if (write_value[1:0] == MASTER_CLR) begin
							nxt.mode.master = 1'b0;
						end
					end
					CMD_PTR_MASK: nxt.ptr = PTR_MASK_REG;
					CMD_PTR_ACR:  nxt.ptr = PTR_ACR_REG;
					CMD_PTR_VEC:  nxt.ptr = {1'b0, write_value[2:0]};
					default: ;
				endcase
			end
			REQ_DATA_RD: begin
				unique case (cur.mode.presel)
					PRESEL_ISR:  read_data = cur.svc;
					PRESEL_MASK: read_data = cur.mask;
					PRESEL_REQ:  read_data = cur.req;
					PRESEL_ACR:  read_data = cur.acr;
				endcase
			end
			REQ_RAISE: begin
				if (src_ok) begin
					nxt.req = cur.req | src_bit;
				end
			end
			REQ_CLEAR: begin
				if (src_ok) begin
					nxt.req = cur.req & ~src_bit;
				end
			end
			REQ_EVAL: ;
			default: ;
		endcase
	end

endmodule

// ----- rtl/pic_resolve.sv -----
module pic_resolve #(
	parameter int unsigned NUM_SOURCES = pic_pkg::PIC_NUM_SOURCES
) (
	input  pic_pkg::pic_state_t st_in,
	input  logic [7:0]          vec [NUM_SOURCES],
	input  logic                do_eval,
	input  logic                duart_pending,
	input  logic                interrupt_enable,
	input  logic                line_in,
	input  logic [7:0]          dvec_in,
	output pic_pkg::pic_state_t st_out,
	output logic                line_out,
	output logic [7:0]          dvec_out
);
	import pic_pkg::*;

	localparam logic [7:0] SRC_MASK = src_mask(NUM_SOURCES);

	logic [7:0] pending;
	logic [7:0] win;
	logic [7:0] win_vec;

	always_comb begin
		pending = '0;
		win     = '0;
		win_vec = '0;
		st_out   = st_in;
		line_out = line_in;
		dvec_out = dvec_in;
		if (do_eval) begin
			st_out.req[0] = duart_pending;
			if (!(interrupt_enable && st_in.mode.master)) begin
				line_out = 1'b0;
			end else begin
				pending = st_out.req & ~st_in.mask & SRC_MASK;
				win     = lowest_one(pending);
				// win is one-hot, so an or-mux picks the vector
				for (int unsigned i = 0; i < NUM_SOURCES; i++) begin
					if (win[i]) begin
						win_vec = win_vec | vec[i];
					end
				end
				if (pending != 8'h00) begin
					st_out.svc = st_in.svc | win;
					st_out.req = st_out.req & ~(win & st_in.acr);
					line_out   = 1'b1;
					dvec_out   = win_vec;
				end else begin
					line_out = 1'b0;
				end
			end
		end
	end

endmodule

// ----- sim/tb_top.sv -----
import pic_pkg::*;

typedef struct {
	logic [7:0] rd;
	logic       line;
	logic [7:0] vec;
	logic [7:0] svc;
} irq_outcome_t;

// request kinds past the last defined one, handled as a plain re-evaluation
localparam logic [2:0] REQ_UNDEF_LO = 3'd6;
localparam logic [2:0] REQ_UNDEF_HI = 3'd7;

class irq_tracker;
	logic [7:0] req_r;
	logic [7:0] mask_r;
	logic [7:0] svc_r;
	logic [7:0] acr_r;
	pic_mode_t  mode_r;
	logic [3:0] ptr_r;
	logic [7:0] vec_r [8];
	logic       line_r;
	logic [7:0] drv_r;
	irq_outcome_t awaited[$];
	int unsigned failures;

	function new();
		clear_regs();
		line_r = 1'b0;
		drv_r = 8'h00;
		failures = 0;
	endfunction

	function void clear_regs();
		req_r = 8'h00;
		mask_r = 8'hFF;
		svc_r = 8'h00;
		acr_r = 8'h00;
		mode_r = '0;
		ptr_r = 4'h0;
		for (int i = 0; i < 8; i++) vec_r[i] = 8'h00;
	endfunction

	function void evaluate(logic duart, logic ien);
		logic [7:0] pend;
		logic won;
		req_r[0] = duart;
		line_r = 1'b0;
		won = 1'b0;
		if (ien && mode_r.master) begin
			pend = req_r & ~mask_r;
			for (int i = 0; i < PIC_NUM_SOURCES; i++) begin
				if (!won && pend[i]) begin
					won = 1'b1;
					svc_r[i] = 1'b1;
					if (acr_r[i]) req_r[i] = 1'b0;
					drv_r = vec_r[i];
					line_r = 1'b1;
				end
			end
		end
	endfunction

	function void command(logic [7:0] v);
		logic [3:0] code;
		logic one;
		logic [7:0] sel;
		code = v[7:4];
		one = v[3];
		sel = 8'd1 << v[2:0];
		case (code)
			CMD_RESET: clear_regs();
			CMD_CLR_REQ_MASK: begin
				req_r = one ? (req_r & ~sel) : 8'h00;
				mask_r = one ? (mask_r & ~sel) : 8'h00;
			end
			CMD_SET_MASK: mask_r = one ? (mask_r | sel) : 8'hFF;
			CMD_CLR_REQ: req_r = one ? (req_r & ~sel) : 8'h00;
			// drop the lowest set in-service bit
			CMD_CLR_LOW_ISR: svc_r = svc_r & (svc_r - 8'd1);
			CMD_CLR_ISR: svc_r = one ? (svc_r & ~sel) : 8'h00;
			CMD_MODE_A, CMD_MODE_B: mode_r.load = v[4:0];
			CMD_PRESEL: begin
				mode_r.presel = v[3:2];
				if (v[1:0] == MASTER_SET) mode_r.master = 1'b1;
				else if (v[1:0] == MASTER_CLR) mode_r.master = 1'b0;
			end
			CMD_PTR_MASK: ptr_r = PTR_MASK_REG;
			CMD_PTR_ACR: ptr_r = PTR_ACR_REG;
			CMD_PTR_VEC: ptr_r = {1'b0, v[2:0]};
			default: ;
		endcase
	endfunction

	function void take_request(logic [2:0] kind, logic [15:0] data);
		logic [7:0] v;
		logic [2:0] src;
		irq_outcome_t o;
		v = data[7:0];
		src = data[10:8];
		o.rd = 8'h00;
		case (kind)
			REQ_DATA_WR: begin
				if (ptr_r == PTR_MASK_REG) mask_r = v;
				else if (ptr_r == PTR_ACR_REG) acr_r = v;
				else vec_r[ptr_r[2:0]] = v & VECTOR_MASK;
			end
			REQ_CMD_WR: command(v);
			REQ_DATA_RD: begin
				case (mode_r.presel)
					PRESEL_ISR: o.rd = svc_r;
					PRESEL_MASK: o.rd = mask_r;
					PRESEL_REQ: o.rd = req_r;
					default: o.rd = acr_r;
				endcase
			end
			REQ_RAISE: if (src < PIC_NUM_SOURCES) req_r[src] = 1'b1;
			REQ_CLEAR: if (src < PIC_NUM_SOURCES) req_r[src] = 1'b0;
			default: ;
		endcase
		if (kind != REQ_DATA_RD) evaluate(data[11], data[12]);
		o.line = line_r;
		o.vec = drv_r;
		o.svc = svc_r;
		awaited.push_back(o);
	endfunction

	function void match_result(logic [31:0] d);
		irq_outcome_t e;
		if (awaited.size() == 0) begin
			$error("result %h with no request outstanding", d);
			failures++;
			return;
		end
		e = awaited.pop_front();
		if (d[7:0] !== e.rd) begin
			$error("read_data expected %h actual %h", e.rd, d[7:0]);
			failures++;
		end
		if (d[8] !== e.line) begin
			$error("irq_request expected %b actual %b", e.line, d[8]);
			failures++;
		end
		if (d[16:9] !== e.vec) begin
			$error("irq_vector expected %h actual %h", e.vec, d[16:9]);
			failures++;
		end
		if (d[24:17] !== e.svc) begin
			$error("in_service expected %h actual %h", e.svc, d[24:17]);
			failures++;
		end
	endfunction
endclass

module tb_top;
	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// write_value[7:0], source_index[10:8], duart_pending[11],
	// interrupt_enable[12], zero[15:13]
	logic [15:0] s_axis_tdata;
	// req_type[2:0]
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// read_data[7:0], irq_request[8], irq_vector[16:9], in_service[24:17],
	// zero[31:25]
	logic [31:0] m_axis_tdata;

	int unsigned send_idle = 38;
	int unsigned recv_idle = 49;
	irq_tracker tracker = new();

	priority_interrupt_controller_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) tracker.match_result(m_axis_tdata);
	end

	// called at a falling edge, returns at the falling edge after the request is taken
	task automatic send_request(input logic [2:0] kind, input logic [7:0] value,
			input logic [2:0] src, input logic duart, input logic ien);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {3'b000, ien, duart, src, value};
		do @(posedge clk); while (!s_axis_tready);
		tracker.take_request(kind, {3'b000, ien, duart, src, value});
		@(negedge clk);
	endtask

	task automatic send_cmd(input logic [7:0] value);
		send_request(REQ_CMD_WR, value, 3'd0, 1'b0, 1'b1);
	endtask

	task automatic send_random_request();
		int unsigned pick;
		logic [2:0] kind;
		logic [7:0] v;
		logic [3:0] code;
		pick = $urandom_range(99);
		v = 8'($urandom);
		if (pick < 30) begin
			kind = REQ_CMD_WR;
			code = 4'($urandom_range(15));
			// keep full resets rare so the controller stays armed
			if (code == CMD_RESET && $urandom_range(7) != 0) code = CMD_PRESEL;
			if (code == CMD_PRESEL && $urandom_range(1) != 0) v[1:0] = MASTER_SET;
			v[7:4] = code;
		end else if (pick < 45) kind = REQ_DATA_WR;
		else if (pick < 55) kind = REQ_DATA_RD;
		else if (pick < 80) kind = REQ_RAISE;
		else if (pick < 90) kind = REQ_CLEAR;
		else if (pick < 97) kind = REQ_EVAL;
		else kind = ($urandom_range(1) != 0) ? REQ_UNDEF_HI : REQ_UNDEF_LO;
		send_request(kind, v, 3'($urandom_range(7)), ($urandom_range(3) == 0),
			($urandom_range(9) != 0));
	endtask

	initial begin
		#3_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = REQ_EVAL;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: every command but mode A and the mask pointer, every read select, source 0 override
		send_request(REQ_DATA_RD, 8'h00, 3'd0, 1'b0, 1'b1);
		send_cmd({CMD_PRESEL, PRESEL_MASK, MASTER_SET});
		send_request(REQ_DATA_RD, 8'hFF, 3'd7, 1'b1, 1'b1);
		send_cmd({CMD_PTR_VEC, 4'h7});
		send_request(REQ_DATA_WR, 8'hFF, 3'd0, 1'b0, 1'b1);
		send_cmd({CMD_CLR_REQ_MASK, 4'h0});
		send_request(REQ_RAISE, 8'h00, 3'd7, 1'b0, 1'b1);
		send_cmd({CMD_PTR_ACR, 4'h0});
		send_request(REQ_DATA_WR, 8'hFF, 3'd0, 1'b0, 1'b1);
		send_request(REQ_RAISE, 8'h00, 3'd0, 1'b0, 1'b1);
		send_request(REQ_EVAL, 8'h00, 3'd0, 1'b1, 1'b1);
		send_request(REQ_EVAL, 8'h00, 3'd0, 1'b1, 1'b0);
		send_cmd({CMD_PRESEL, PRESEL_REQ, 2'b00});
		send_request(REQ_DATA_RD, 8'h00, 3'd0, 1'b0, 1'b1);
		send_cmd({CMD_CLR_LOW_ISR, 4'h0});
		send_cmd({CMD_CLR_ISR, 4'hF});
		send_cmd({CMD_CLR_ISR, 4'h0});
		send_cmd({CMD_MODE_B, 4'hF});
		send_cmd({CMD_SET_MASK, 4'hB});
		send_cmd({CMD_CLR_REQ, 4'hD});
		send_cmd(8'h5A);
		send_cmd(8'hDF);
		send_request(REQ_UNDEF_LO, 8'h00, 3'd0, 1'b1, 1'b1);
		send_request(REQ_UNDEF_HI, 8'h00, 3'd0, 1'b0, 1'b1);
		send_cmd({CMD_PRESEL, PRESEL_ACR, MASTER_CLR});
		send_request(REQ_DATA_RD, 8'h00, 3'd0, 1'b0, 1'b1);
		send_request(REQ_CLEAR, 8'h00, 3'd3, 1'b0, 1'b1);
		send_cmd({CMD_RESET, 4'h0});

		repeat (260) send_random_request();
		send_idle = 49;
		recv_idle = 38;
		repeat (270) send_random_request();
		send_idle = 0;
		recv_idle = 0;
		repeat (270) send_random_request();
		s_axis_tvalid <= 1'b0;

		while (tracker.awaited.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.failures == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

// ----- priority_interrupt_controller_unit.f -----
+incdir+rtl
rtl/pic_pkg.sv
rtl/pic_action.sv
rtl/pic_resolve.sv
rtl/priority_interrupt_controller_unit.sv
sim/tb_top.sv
